### design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console writer
// Grid geometry, control codes, packing widths and the command/status
// structs passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // grid geometry
    localparam int COLUMNS = 70;
    localparam int LINES   = 20;
    localparam int CELLS   = COLUMNS * LINES;
    localparam int TAB_W   = 8;

    localparam int COL_W  = $clog2(COLUMNS + 1);   // cursor column, COLUMNS = wrap pending
    localparam int ROW_W  = $clog2(LINES);
    localparam int ADDR_W = $clog2(CELLS);

    // fixed field widths
    localparam int CHAR_W  = 8;
    localparam int RCOL_W  = 7;
    localparam int RROW_W  = 5;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;

    // control characters
    localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NL  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0]        RESET_ATTR = 8'h0F;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 2'd1;

    // item modes
    localparam logic MODE_PUT  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic load_item;   // capture input word
        logic clear_wr;    // reset sweep write
        logic fill_wr;     // scroll fill write
        logic wr_en;       // item cell write
        logic rd_en;       // cell read
        logic cnt_inc;
        logic cnt_clr;
        logic top_adv;     // advance ring top row
        logic commit;      // update cursor and scroll flag
        logic out_load;    // load result register
    } t_dp_cmd;

    typedef struct packed {
        logic mode_read;
        logic need_scroll;
        logic has_write;
        logic clear_last;
        logic fill_last;
        logic out_free;
    } t_dp_stat;

endpackage

### design/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit: 70 x 20 character-cell console writer
// Items enter on the s_axis channel: tuser selects put (0) or read (1),
// tdata carries the character and the cell position for a read.
// Each item gives one result word on m_axis: cursor after the item, the
// cell read (zero for puts) and a scroll flag.
// Colors are set on the cfg channel: index 0 foreground, 1 background;
// it is always ready and must only be written while the block is idle.
// An accepted item passes through execute and, for a put that scrolls, a
// bottom-row fill of 70 cells (one cell per cycle through the single write
// port) plus a cell write for a character placed after the scroll, then
// into the result register once it is free. The next item can be accepted
// in the cycle after the result is loaded, so items never overlap.
// Scrolling moves a ring pointer over the rows; cells are not copied.
// After reset the block clears all 1400 cells, one per cycle, with
// s_axis_tready low; cursor goes to row 0 column 0, colors to 15 on 0.
// The result sits in an output register: while m_axis_tready is low the
// next item is still accepted and executed, then waits for the slot.
// ----------------------------------------------------------------------------
module text_console_writer_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // mode
    input  logic                               s_axis_tuser,
    // [7:0] char_code, [14:8] read_column, [19:15] read_row
    input  logic [tcw_pkg::IN_W-1:0]           s_axis_tdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [6:0] cursor_column, [11:7] cursor_line, [19:12] cell_char,
    // [27:20] cell_attr, [28] scrolled
    output logic [tcw_pkg::OUT_W-1:0]          m_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tcw_pkg::CFG_DAT_W-1:0]      i_cfg_data
);
    import tcw_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tcw_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_item_user (s_axis_tuser),
        .i_item_data (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

### design/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath: cell memory, cursor and result register
// Holds the cell memory as a ring of rows, the cursor, color registers,
// the sweep counter and the output register. Driven by tcw_ctrl.
// ----------------------------------------------------------------------------
module tcw_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tcw_pkg::t_dp_cmd                   i_cmd,
    output tcw_pkg::t_dp_stat                  o_stat,
    input  logic                               i_item_user,
    input  logic [tcw_pkg::IN_W-1:0]           i_item_data,
    input  logic                               i_cfg_valid,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tcw_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [tcw_pkg::OUT_W-1:0]          o_out_data
);
    import tcw_pkg::*;

    // logical row to physical row through the ring top
    function automatic logic [ROW_W-1:0] row_map(input logic [ROW_W-1:0] top,
                                                 input logic [ROW_W-1:0] row);
        logic [ROW_W:0] sum;
        sum = {1'b0, top} + {1'b0, row};
        if (sum >= (ROW_W+1)'(LINES)) begin
            sum = sum - (ROW_W+1)'(LINES);
        end
        return sum[ROW_W-1:0];
    endfunction

    logic [15:0]           r_mem [CELLS];
    logic [15:0]           r_rd_data;
    logic                  r_rd_ok;

    logic                  r_mode;
    logic [CHAR_W-1:0]     r_char;
    logic [RCOL_W-1:0]     r_rcol;
    logic [RROW_W-1:0]     r_rrow;

    logic [COL_W-1:0]      r_col;
    logic [ROW_W-1:0]      r_row;
    logic [ROW_W-1:0]      r_top;
    logic [3:0]            r_fg;
    logic [3:0]            r_bg;
    logic [ADDR_W-1:0]     r_cnt;
    logic                  r_scrolled;
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data;

    logic [COL_W:0]        col_ext;
    logic [COL_W:0]        tab_col;
    logic [COL_W-1:0]      n_col;
    logic [ROW_W:0]        raw_row;
    logic [COL_W-1:0]      wr_col;
    logic                  has_write;
    logic [CHAR_W-1:0]     wr_char;
    logic                  need_scroll;
    logic [ROW_W-1:0]      fin_row;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     fill_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  rd_ok;
    logic [7:0]            attr;
    logic [ADDR_W-1:0]     mem_addr;
    logic [15:0]           mem_data;
    logic                  mem_we;
    logic [7:0]            cell_char;
    logic [7:0]            cell_attr;

    assign attr    = {r_bg, r_fg};
    assign col_ext = {1'b0, r_col};
    assign tab_col = (col_ext + (COL_W+1)'(TAB_W)) & ~(COL_W+1)'(TAB_W - 1);

    // next cursor and cell write for a put item
    always_comb begin
        n_col     = r_col;
        raw_row   = {1'b0, r_row};
        wr_col    = r_col;
        has_write = 1'b0;
        wr_char   = r_char;
        case (r_char)
            CH_NL: begin
                n_col   = '0;
                raw_row = {1'b0, r_row} + (ROW_W+1)'(1);
            end
            CH_CR: begin
                n_col = '0;
            end
            CH_BS: begin
                if (r_col != '0) begin
                    n_col     = r_col - COL_W'(1);
                    wr_col    = r_col - COL_W'(1);
                    has_write = 1'b1;
                    wr_char   = BLANK_CHAR;
                end
            end
            CH_TAB: begin
                if (tab_col >= (COL_W+1)'(COLUMNS)) begin
                    n_col   = '0;
                    raw_row = {1'b0, r_row} + (ROW_W+1)'(1);
                end else begin
                    n_col = tab_col[COL_W-1:0];
                end
            end
            default: begin
                // printable: wrap pending moves to the next row first
                if (r_col >= COL_W'(COLUMNS)) begin
                    wr_col  = '0;
                    raw_row = {1'b0, r_row} + (ROW_W+1)'(1);
                end
                has_write = 1'b1;
                n_col     = wr_col + COL_W'(1);
            end
        endcase
    end

    assign need_scroll = (raw_row >= (ROW_W+1)'(LINES));
    assign fin_row     = need_scroll ? ROW_W'(LINES - 1) : raw_row[ROW_W-1:0];

    // cell addresses
    assign wr_addr   = ADDR_W'(row_map(r_top, fin_row)) * ADDR_W'(COLUMNS)
                     + ADDR_W'(wr_col);
    assign fill_addr = ADDR_W'(r_top) * ADDR_W'(COLUMNS) + r_cnt;
    assign rd_ok     = (r_rcol < RCOL_W'(COLUMNS)) && (r_rrow < RROW_W'(LINES));
    assign rd_addr   = ADDR_W'(row_map(r_top, r_rrow[ROW_W-1:0])) * ADDR_W'(COLUMNS)
                     + ADDR_W'(r_rcol);

    // memory write port select
    always_comb begin
        mem_we   = 1'b0;
        mem_addr = wr_addr;
        mem_data = {attr, wr_char};
        if (i_cmd.clear_wr) begin
            mem_we   = 1'b1;
            mem_addr = r_cnt;
            mem_data = {RESET_ATTR, BLANK_CHAR};
        end else if (i_cmd.fill_wr) begin
            mem_we   = 1'b1;
            mem_addr = fill_addr;
            mem_data = {attr, BLANK_CHAR};
        end else if (i_cmd.wr_en) begin
            mem_we = 1'b1;
        end
    end

    // cell memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // item capture and read range flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_mode <= i_item_user;
            r_char <= i_item_data[CHAR_W-1:0];
            r_rcol <= i_item_data[CHAR_W +: RCOL_W];
            r_rrow <= i_item_data[CHAR_W+RCOL_W +: RROW_W];
        end
        if (i_cmd.rd_en) begin
            r_rd_ok <= rd_ok;
        end
    end

    // cursor, ring top, colors, sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_top      <= '0;
            r_fg       <= 4'hF;
            r_bg       <= 4'h0;
            r_cnt      <= '0;
            r_scrolled <= 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_index == CFG_FG) begin
                r_fg <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == CFG_BG) begin
                r_bg <= i_cfg_data;
            end
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + ADDR_W'(1);
            end
            if (i_cmd.top_adv) begin
                r_top <= (r_top == ROW_W'(LINES - 1)) ? '0 : r_top + ROW_W'(1);
            end
            if (i_cmd.load_item) begin
                r_scrolled <= 1'b0;
            end else if (i_cmd.commit) begin
                r_col      <= n_col;
                r_row      <= fin_row;
                r_scrolled <= need_scroll;
            end
        end
    end

    assign cell_char = (r_mode == MODE_READ && r_rd_ok) ? r_rd_data[7:0]  : 8'h00;
    assign cell_attr = (r_mode == MODE_READ && r_rd_ok) ? r_rd_data[15:8] : 8'h00;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {3'b000, r_scrolled, cell_attr, cell_char,
                           RROW_W'(r_row), RCOL_W'(r_col)};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_stat.mode_read   = (r_mode == MODE_READ);
    assign o_stat.need_scroll = need_scroll;
    assign o_stat.has_write   = has_write;
    assign o_stat.clear_last  = (r_cnt == ADDR_W'(CELLS - 1));
    assign o_stat.fill_last   = (r_cnt == ADDR_W'(COLUMNS - 1));
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

endmodule

### design/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl: sequencing controller
// Runs the memory clear after reset, then steps each item through
// execute, optional scroll fill, optional cell write and result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tcw_pkg::t_dp_stat   i_stat,
    output tcw_pkg::t_dp_cmd    o_cmd
);
    import tcw_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_WRITE,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                o_cmd.cnt_inc  = 1'b1;
                if (i_stat.clear_last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_stat.mode_read) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = ST_DONE;
                end else if (i_stat.need_scroll) begin
                    n_state = ST_FILL;
                end else begin
                    o_cmd.wr_en  = i_stat.has_write;
                    o_cmd.commit = 1'b1;
                    n_state      = ST_DONE;
                end
            end
            ST_FILL: begin
                // blank the old top row, which becomes the new bottom row
                o_cmd.fill_wr = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_stat.fill_last) begin
                    o_cmd.cnt_clr = 1'b1;
                    o_cmd.top_adv = 1'b1;
                    if (i_stat.has_write) begin
                        n_state = ST_WRITE;
                    end else begin
                        o_cmd.commit = 1'b1;
                        n_state      = ST_DONE;
                    end
                end
            end
            ST_WRITE: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.commit = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

### tb/tb_text_console_writer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer_unit: self-checking bench for the text console writer
// A short table of directed words walks the reset state, off-grid reads and
// every control character, then random traffic runs in several color phases
// with random idling on both stream sides except in the steady phase. Random
// traffic is mostly newline plus printable runs, some of exactly one full
// line to exercise the wrap-pending column and scrolling. Each result word
// is checked against its typed table entry or a model of grid, cursor, colors.
// ----------------------------------------------------------------------------
module tb_text_console_writer_unit;
    import tcw_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 5;
    localparam int PHASE_WORDS = 230;

    // result word, field order matches m_axis_tdata from bit 28 down
    typedef struct packed {
        logic       scrolled;
        logic [7:0] attr;
        logic [7:0] chr;
        logic [4:0] line;
        logic [6:0] col;
    } t_console_word;

    // one directed word; the expected fields count only when typed is set
    typedef struct {
        logic       md;
        logic [7:0] ch;
        logic [6:0] rc;
        logic [4:0] rr;
        bit         typed;
        logic [6:0] e_col;
        logic [4:0] e_line;
        logic [7:0] e_chr;
        logic [7:0] e_attr;
        logic       e_scr;
    } t_directed_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tuser;
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    // model of the console
    logic [15:0]   screen [CELLS];
    int            cur_col;
    int            cur_row;
    logic [3:0]    fg_colour;
    logic [3:0]    bg_colour;
    t_console_word awaited_words [$];

    // typed expectation travels with the word on the bus
    bit            typed_pending;
    t_console_word typed_word;
    bit            steady;
    int            mismatch_count;
    int            cycle_count;

    t_directed_row directed_steps [25] = '{
        // reset state and reads off the grid
        '{MODE_READ, 8'h00, 7'd0,   5'd0,  1'b1, 7'd0,  5'd0, 8'h20, 8'h0F, 1'b0},
        '{MODE_READ, 8'h00, 7'd127, 5'd31, 1'b1, 7'd0,  5'd0, 8'h00, 8'h00, 1'b0},
        '{MODE_READ, 8'h00, 7'd69,  5'd19, 1'b1, 7'd0,  5'd0, 8'h20, 8'h0F, 1'b0},
        '{MODE_READ, 8'h00, 7'd70,  5'd19, 1'b1, 7'd0,  5'd0, 8'h00, 8'h00, 1'b0},
        '{MODE_READ, 8'h00, 7'd0,   5'd20, 1'b1, 7'd0,  5'd0, 8'h00, 8'h00, 1'b0},
        // backspace at column zero does nothing
        '{MODE_PUT,  CH_BS, 7'd0,   5'd0,  1'b1, 7'd0,  5'd0, 8'h00, 8'h00, 1'b0},
        '{MODE_PUT,  8'h41, 7'd0,   5'd0,  1'b1, 7'd1,  5'd0, 8'h00, 8'h00, 1'b0},
        '{MODE_READ, 8'hFF, 7'd0,   5'd0,  1'b1, 7'd1,  5'd0, 8'h41, 8'h0F, 1'b0},
        '{MODE_PUT,  CH_TAB, 7'd127, 5'd31, 1'b1, 7'd8, 5'd0, 8'h00, 8'h00, 1'b0},
        '{MODE_PUT,  CH_CR, 7'd0,   5'd0,  1'b1, 7'd0,  5'd0, 8'h00, 8'h00, 1'b0},
        '{MODE_PUT,  8'h00, 7'd0,   5'd0,  1'b1, 7'd1,  5'd0, 8'h00, 8'h00, 1'b0},
        '{MODE_PUT,  8'hFF, 7'd0,   5'd0,  1'b1, 7'd2,  5'd0, 8'h00, 8'h00, 1'b0},
        // backspace blanks the cell it steps onto
        '{MODE_PUT,  CH_BS, 7'd0,   5'd0,  1'b1, 7'd1,  5'd0, 8'h00, 8'h00, 1'b0},
        '{MODE_READ, 8'h00, 7'd1,   5'd0,  1'b1, 7'd1,  5'd0, 8'h20, 8'h0F, 1'b0},
        '{MODE_READ, 8'h00, 7'd0,   5'd0,  1'b1, 7'd1,  5'd0, 8'h00, 8'h0F, 1'b0},
        '{MODE_PUT,  CH_NL, 7'd0,   5'd0,  1'b1, 7'd0,  5'd1, 8'h00, 8'h00, 1'b0},
        // tab stops across the row, the last one wraps
        '{MODE_PUT,  CH_TAB, 7'd0,  5'd0,  1'b0, 7'd0,  5'd0, 8'h00, 8'h00, 1'b0},
        '{MODE_PUT,  CH_TAB, 7'd0,  5'd0,  1'b0, 7'd0,  5'd0, 8'h00, 8'h00, 1'b0},
        '{MODE_PUT,  CH_TAB, 7'd0,  5'd0,  1'b0, 7'd0,  5'd0, 8'h00, 8'h00, 1'b0},
        '{MODE_PUT,  CH_TAB, 7'd0,  5'd0,  1'b0, 7'd0,  5'd0, 8'h00, 8'h00, 1'b0},
        '{MODE_PUT,  CH_TAB, 7'd0,  5'd0,  1'b0, 7'd0,  5'd0, 8'h00, 8'h00, 1'b0},
        '{MODE_PUT,  CH_TAB, 7'd0,  5'd0,  1'b0, 7'd0,  5'd0, 8'h00, 8'h00, 1'b0},
        '{MODE_PUT,  CH_TAB, 7'd0,  5'd0,  1'b0, 7'd0,  5'd0, 8'h00, 8'h00, 1'b0},
        '{MODE_PUT,  CH_TAB, 7'd0,  5'd0,  1'b0, 7'd0,  5'd0, 8'h00, 8'h00, 1'b0},
        '{MODE_PUT,  CH_TAB, 7'd0,  5'd0,  1'b1, 7'd0,  5'd2, 8'h00, 8'h00, 1'b0}
    };

    text_console_writer_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // whole grid moves up one row, new bottom row blank in current colors
    task automatic scroll_screen();
        for (int i = 0; i < CELLS - COLUMNS; i++) begin
            screen[i] = screen[i + COLUMNS];
        end
        for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
            screen[i] = {bg_colour, fg_colour, BLANK_CHAR};
        end
    endtask

    // apply one accepted word to the model and return its result word
    task automatic advance_console(input logic md, input logic [7:0] ch,
                                   input logic [6:0] rc, input logic [4:0] rr,
                                   output t_console_word w);
        int col;
        int row;
        int addr;
        w   = '0;
        col = cur_col;
        row = cur_row;
        if (md == MODE_READ) begin
            if (rc < COLUMNS && rr < LINES) begin
                addr   = rr * COLUMNS + rc;
                w.chr  = screen[addr][7:0];
                w.attr = screen[addr][15:8];
            end
        end else begin
            case (ch)
                CH_NL: begin
                    col = 0;
                    row++;
                end
                CH_CR: col = 0;
                CH_BS: begin
                    if (col > 0) begin
                        col--;
                        screen[row * COLUMNS + col] = {bg_colour, fg_colour, BLANK_CHAR};
                    end
                end
                CH_TAB: begin
                    col = (col + TAB_W) & ~(TAB_W - 1);
                    if (col >= COLUMNS) begin
                        col = 0;
                        row++;
                    end
                end
                default: begin
                    // pending wrap resolves before the character lands
                    if (col >= COLUMNS) begin
                        col = 0;
                        row++;
                    end
                    if (row >= LINES) begin
                        scroll_screen();
                        w.scrolled = 1'b1;
                        row = LINES - 1;
                    end
                    screen[row * COLUMNS + col] = {bg_colour, fg_colour, ch};
                    col++;
                end
            endcase
            if (row >= LINES) begin
                scroll_screen();
                w.scrolled = 1'b1;
                row = LINES - 1;
            end
        end
        cur_col = col;
        cur_row = row;
        w.col   = col[6:0];
        w.line  = row[4:0];
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // present one word on s_axis, after a random gap unless steady is set, and return once it is taken
    task automatic send_item(input logic md, input logic [7:0] ch, input logic [6:0] rc,
                             input logic [4:0] rr, input bit typed, input t_console_word want);
        while (!steady && $urandom_range(99) < 16) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= md;
        s_axis_tdata  <= {4'b0, rr, rc, ch};
        typed_pending <= typed;
        typed_word    <= want;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // hold off the sender until every result word is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (awaited_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // result side back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 16);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("text_console_writer_unit test failed");
            $finish;
        end
    end

    // monitor: check results, then record accepted words and register writes
    always @(posedge i_clk) begin
        t_console_word got;
        t_console_word want;
        t_console_word pred;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[28:0];
                if (awaited_words.size() == 0) begin
                    $error("result word %h with nothing expected", m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = awaited_words.pop_front();
                    check_field("cursor_column", int'(want.col), int'(got.col));
                    check_field("cursor_line", int'(want.line), int'(got.line));
                    check_field("cell_char", int'(want.chr), int'(got.chr));
                    check_field("cell_attr", int'(want.attr), int'(got.attr));
                    check_field("scrolled", int'(want.scrolled), int'(got.scrolled));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                advance_console(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[14:8],
                                s_axis_tdata[19:15], pred);
                awaited_words.push_back(typed_pending ? typed_word : pred);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FG:  fg_colour = i_cfg_data;
                    CFG_BG:  bg_colour = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    initial begin
        logic          md;
        logic [7:0]    ch;
        logic [6:0]    rc;
        logic [4:0]    rr;
        int unsigned   roll;
        int unsigned   run_left;
        int            sent;
        logic [3:0]    new_fg;
        logic [3:0]    new_bg;
        t_console_word want;

        for (int i = 0; i < CELLS; i++) screen[i] = {RESET_ATTR, BLANK_CHAR};
        cur_col        = 0;
        cur_row        = 0;
        fg_colour      = 4'd15;
        bg_colour      = 4'd0;
        mismatch_count = 0;
        cycle_count    = 0;
        run_left       = 0;
        steady         = 1'b0;
        typed_pending  = 1'b0;
        typed_word     = '0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tuser   = MODE_PUT;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_FG;
        i_cfg_data     = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table under reset colors
        foreach (directed_steps[k]) begin
            want = {directed_steps[k].e_scr, directed_steps[k].e_attr, directed_steps[k].e_chr,
                    directed_steps[k].e_line, directed_steps[k].e_col};
            send_item(directed_steps[k].md, directed_steps[k].ch, directed_steps[k].rc,
                      directed_steps[k].rr, directed_steps[k].typed, want);
        end
        drain_results();

        // random traffic, one color setting per phase
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin new_fg = 4'd0;  new_bg = 4'd15; end
                1: begin new_fg = 4'd15; new_bg = 4'd15; end
                2: begin new_fg = 4'd0;  new_bg = 4'd0;  end
                default: begin
                    new_fg = 4'($urandom_range(15));
                    new_bg = 4'($urandom_range(15));
                end
            endcase
            steady <= (p == 2);

            // block is idle here: write both color registers
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_FG;
            i_cfg_data  <= new_fg;
            do @(posedge i_clk); while (!o_cfg_ready);
            i_cfg_index <= CFG_BG;
            i_cfg_data  <= new_bg;
            do @(posedge i_clk); while (!o_cfg_ready);
            i_cfg_valid <= 1'b0;

            sent = 0;
            while (sent < PHASE_WORDS) begin
                md   = MODE_PUT;
                ch   = 8'($urandom_range(255));
                rc   = 7'($urandom_range(127));
                rr   = 5'($urandom_range(31));
                roll = $urandom_range(99);
                if (run_left > 0) begin
                    // printable run, control codes moved out of the way
                    run_left--;
                    if (ch == CH_BS || ch == CH_TAB || ch == CH_NL || ch == CH_CR) begin
                        ch = ch | 8'h40;
                    end
                end else if (roll < 6) begin
                    // newline then a run; a full line leaves the wrap pending
                    ch       = CH_NL;
                    run_left = ($urandom_range(2) == 0) ? COLUMNS : $urandom_range(1, 30);
                end else if (roll < 14) begin
                    ch = CH_NL;
                end else if (roll < 18) begin
                    ch = CH_CR;
                end else if (roll < 26) begin
                    ch = CH_BS;
                end else if (roll < 32) begin
                    ch = CH_TAB;
                end else if (roll < 67) begin
                    md = MODE_READ;
                    if ($urandom_range(4) != 0) rc = 7'($urandom_range(COLUMNS - 1));
                    if ($urandom_range(4) != 0) rr = 5'($urandom_range(LINES - 1));
                end
                send_item(md, ch, rc, rr, 1'b0, '0);
                sent++;
            end
            drain_results();
        end

        // let any stray result word show up
        repeat (80) @(posedge i_clk);
        if (awaited_words.size() != 0) begin
            $error("%0d result words never arrived", awaited_words.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("text_console_writer_unit test passed");
        end else begin
            $display("text_console_writer_unit test failed");
        end
        $finish;
    end

endmodule

### filelist.f
design/tcw_pkg.sv
design/tcw_datapath.sv
design/tcw_ctrl.sv
design/text_console_writer_unit.sv
tb/tb_text_console_writer_unit.sv
